// ----- rtl/core/bvq_pkg.sv -----
`default_nettype none
package bvq_pkg;

   // field and state widths
   localparam int CNT_W      = 7;
   localparam int WIN_W      = 7;
   localparam int LOCK_W     = 10;
   localparam int IDX_OUT_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CNT_W-1:0]  CNT_MAX     = 7'd127;
   localparam logic [LOCK_W-1:0] ELAPSED_MAX = 10'd1023;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VOTES = 2'd2;

   // reset values of the registers
   localparam logic [LOCK_W-1:0] LOCKOUT_RST   = 10'd300;
   localparam logic [WIN_W-1:0]  WINDOW_RST    = 7'd50;
   localparam logic [CNT_W-1:0]  MIN_VOTES_RST = 7'd5;

   // per-beat control from the sequencer to lanes and merge
   typedef struct packed {
      logic count_en;
      logic close;
      logic open;
   } seq_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/core/button_vote_qualifier_unit.sv -----
`default_nettype none
// button vote qualifier: lockout on falling edges, then a per-button vote window
// a closing beat snapshots the counts into the judge stage, whose winner then moves to the output register
// throughput: one beat per cycle, one lane per button counts in parallel
// the input stalls only while a judged window waits behind a held result beat
// reset (synchronous, active high) clears timer, flags, counts, and loads
// register defaults: lockout 300, window 50, min votes 5
module button_vote_qualifier_unit #(
   parameter int BUTTONS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_ms_tick,
   input  logic                           req_any_falling,
   input  logic [BUTTONS-1:0]             req_pressed_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bvq_pkg::IDX_OUT_W-1:0]  rsp_button_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bvq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvq_pkg::CSR_DATA_W-1:0] csr_data
);
   import bvq_pkg::*;

   logic [LOCK_W-1:0] lockout_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [CNT_W-1:0]  min_votes_ff;
   logic              fire, stage_free;
   seq_ctrl_type      ctrl;
   logic [CNT_W-1:0]  final_cnt [BUTTONS];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff   <= LOCKOUT_RST;
         window_ff    <= WINDOW_RST;
         min_votes_ff <= MIN_VOTES_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOCKOUT:   lockout_ff   <= csr_data[LOCK_W-1:0];
            CSR_WINDOW:    window_ff    <= csr_data[WIN_W-1:0];
            CSR_MIN_VOTES: min_votes_ff <= csr_data[CNT_W-1:0];
            default:       ;
         endcase
      end
   end

   // input beat acceptance
   assign req_ready = stage_free;
   assign fire      = req_valid && req_ready;

   bvq_sequencer u_seq (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .ms_tick        (req_ms_tick),
      .any_falling    (req_any_falling),
      .lockout_ms     (lockout_ff),
      .window_samples (window_ff),
      .ctrl           (ctrl)
   );

   // one counting lane per button
   genvar g;
   generate
      for (g = 0; g < BUTTONS; g++) begin : g_lane
         bvq_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .pressed   (req_pressed_mask[g]),
            .final_cnt (final_cnt[g])
         );
      end
   endgenerate

   bvq_merge #(
      .BUTTONS (BUTTONS)
   ) u_merge (
      .clock            (clock),
      .reset            (reset),
      .close            (ctrl.close),
      .final_cnt        (final_cnt),
      .min_votes        (min_votes_ff),
      .stage_free       (stage_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_button_index (rsp_button_index)
   );

endmodule
`default_nettype wire

// ----- rtl/core/bvq_lane.sv -----
`default_nettype none
module bvq_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  bvq_pkg::seq_ctrl_type      ctrl,
   input  logic                       pressed,
   output logic [bvq_pkg::CNT_W-1:0]  final_cnt
);
   import bvq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in, count_t;
   logic [CNT_W-1:0] final_ff;

   // saturating vote count for this button
   always_comb begin
      count_t = count_ff;
      if (ctrl.count_en && pressed && (count_ff != CNT_MAX)) begin
         count_t = count_ff + CNT_W'(1);
      end
      count_in = ctrl.open ? '0 : count_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // snapshot of the count when the window closes
   always_ff @(posedge clock) begin
      if (ctrl.close) begin
         final_ff <= count_t;
      end
   end

   assign final_cnt = final_ff;

endmodule
`default_nettype wire

// ----- rtl/core/bvq_sequencer.sv -----
`default_nettype none
module bvq_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic                        ms_tick,
   input  logic                        any_falling,
   input  logic [bvq_pkg::LOCK_W-1:0]  lockout_ms,
   input  logic [bvq_pkg::WIN_W-1:0]   window_samples,
   output bvq_pkg::seq_ctrl_type       ctrl
);
   import bvq_pkg::*;

   logic [LOCK_W-1:0] elapsed_ff, elapsed_in, elapsed_t;
   logic              pending_ff, pending_in, pending_t;
   logic              active_ff, active_in, active_left;
   logic [WIN_W-1:0]  sample_ff, sample_in, sample_next;
   logic [WIN_W-1:0]  win_len;
   logic              close_w, trig, open_w;

   // window progress
   always_comb begin
      win_len     = (window_samples == '0) ? WIN_W'(1) : window_samples;
      sample_next = sample_ff + WIN_W'(1);
      close_w     = active_ff && (sample_next >= win_len);
      active_left = active_ff && !close_w;
   end

   // lockout timer and edge qualification
   always_comb begin
      elapsed_t = elapsed_ff;
      if (ms_tick && (elapsed_ff != ELAPSED_MAX)) begin
         elapsed_t = elapsed_ff + LOCK_W'(1);
      end
      trig       = any_falling && (elapsed_t > lockout_ms);
      elapsed_in = trig ? '0 : elapsed_t;
      pending_t  = pending_ff || trig;
      open_w     = !active_left && pending_t;
      pending_in = pending_t && !open_w;
      active_in  = active_left || open_w;
      if (open_w) begin
         sample_in = '0;
      end else if (active_ff) begin
         sample_in = sample_next;
      end else begin
         sample_in = sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         pending_ff <= 1'b0;
         active_ff  <= 1'b0;
         sample_ff  <= '0;
      end else if (fire) begin
         elapsed_ff <= elapsed_in;
         pending_ff <= pending_in;
         active_ff  <= active_in;
         sample_ff  <= sample_in;
      end
   end

   assign ctrl.count_en = fire && active_ff;
   assign ctrl.close    = fire && close_w;
   assign ctrl.open     = fire && open_w;

`ifndef SYNTHESIS
   // a pending trigger only survives behind a running window
   assert property (@(posedge clock) disable iff (reset) pending_ff |-> active_ff)
      else $error("trigger pending with no window running");
   // an accepted edge restarts the lockout timer
   assert property (@(posedge clock) disable iff (reset) (fire && trig) |=> elapsed_ff == '0)
      else $error("elapsed timer not restarted on trigger");
   // an opened window starts counting from zero
   assert property (@(posedge clock) disable iff (reset)
      ctrl.open |=> (active_ff && sample_ff == '0))
      else $error("window did not open cleanly");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/bvq_merge.sv -----
`default_nettype none
module bvq_merge #(
   parameter int BUTTONS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          close,
   input  logic [bvq_pkg::CNT_W-1:0]     final_cnt [BUTTONS],
   input  logic [bvq_pkg::CNT_W-1:0]     min_votes,
   output logic                          stage_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bvq_pkg::IDX_OUT_W-1:0] rsp_button_index
);
   import bvq_pkg::*;

   localparam int LVL   = (BUTTONS > 1) ? $clog2(BUTTONS) : 0;
   localparam int PAD   = 1 << LVL;
   localparam int IDX_W = (LVL > 0) ? LVL : 1;

   logic                 judge_valid_ff, judge_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff;
   logic                 rsp_free, emit;
   logic [CNT_W-1:0]     leaf_cnt [PAD];
   logic [CNT_W-1:0]     t_cnt [LVL+1][PAD];
   logic [IDX_W-1:0]     t_idx [LVL+1][PAD];
   logic [IDX_W+IDX_OUT_W-1:0] idx_wide;

   // leaves, padded with empty entries
   genvar g;
   generate
      for (g = 0; g < PAD; g++) begin : g_leaf
         if (g < BUTTONS) begin : g_real
            assign leaf_cnt[g] = final_cnt[g];
         end else begin : g_pad
            assign leaf_cnt[g] = '0;
         end
      end
   endgenerate

   // argmax tree, left wins ties so the lowest index is kept
   always_comb begin
      for (int l = 0; l <= LVL; l++) begin
         for (int k = 0; k < PAD; k++) begin
            t_cnt[l][k] = '0;
            t_idx[l][k] = '0;
         end
      end
      for (int k = 0; k < PAD; k++) begin
         t_cnt[0][k] = leaf_cnt[k];
         t_idx[0][k] = IDX_W'(k);
      end
      for (int l = 0; l < LVL; l++) begin
         for (int k = 0; k < (PAD >> (l + 1)); k++) begin
            if (t_cnt[l][2*k+1] > t_cnt[l][2*k]) begin
               t_cnt[l+1][k] = t_cnt[l][2*k+1];
               t_idx[l+1][k] = t_idx[l][2*k+1];
            end else begin
               t_cnt[l+1][k] = t_cnt[l][2*k];
               t_idx[l+1][k] = t_idx[l][2*k];
            end
         end
      end
      emit     = t_cnt[LVL][0] > min_votes;
      idx_wide = (IDX_W+IDX_OUT_W)'(t_idx[LVL][0]);
   end

   // judge stage and output register flow
   always_comb begin
      rsp_free       = !rsp_valid_ff || rsp_ready;
      stage_free     = !judge_valid_ff || rsp_free;
      judge_valid_in = close || (judge_valid_ff && !rsp_free);
      rsp_valid_in   = rsp_free ? (judge_valid_ff && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         judge_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         judge_valid_ff <= judge_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && judge_valid_ff) begin
         rsp_idx_ff <= idx_wide[IDX_OUT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_index = rsp_idx_ff;

`ifndef SYNTHESIS
   // a window never closes while the judge stage is blocked
   assert property (@(posedge clock) disable iff (reset) close |-> stage_free)
      else $error("window closed into a full judge stage");
   // a new beat on the output always comes from the judge stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(judge_valid_ff))
      else $error("result beat without a judged window");
   // a judged window drains unless a new close refills it
   assert property (@(posedge clock) disable iff (reset)
      (judge_valid_ff && rsp_free) |=> (!judge_valid_ff || $past(close)))
      else $error("judge stage did not drain");
`endif

endmodule
`default_nettype wire
